// ----- sv/cxalu_pkg.sv -----
package cxalu_pkg;

	// word format: signed fixed point, W bits, F of them fractional
	localparam int W  = 32;
	localparam int F  = 16;
	// product, signed sum of two products, magnitude
	localparam int PW = 2 * W;
	localparam int XW = 2 * W + 2;
	localparam int MW = 2 * W + 1;
	// |b|^2, doubled divisor / partial remainder, divider dividend
	localparam int DW = 2 * W;
	localparam int RW = 2 * W + 1;
	localparam int NW = MW + F + 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic signed [W-1:0] a_real;
		logic signed [W-1:0] a_imag;
		logic signed [W-1:0] b_real;
		logic signed [W-1:0] b_imag;
	} operands_t;

	typedef struct packed {
		logic signed [W-1:0] result_real;
		logic signed [W-1:0] result_imag;
		logic                divide_by_zero;
		logic                saturated;
	} result_t;

	// one result part on its way down the divider row
	typedef struct packed {
		logic          neg;   // sign of the result part
		logic          big;   // magnitude is 2^W or more
		logic [W-1:0]  q;     // magnitude (quotient bits for divide)
		logic [RW-1:0] rem;   // partial remainder
		logic [W-1:0]  nlow;  // dividend bits still to enter
	} part_t;

	typedef struct packed {
		logic          is_div;
		logic          dz;
		logic [RW-1:0] d2;    // 2*|b|^2
		part_t         re;
		part_t         im;
	} item_t;

endpackage

// ----- sv/cxalu_front.sv -----
module cxalu_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cxalu_pkg::operands_t  operands,
	output logic                  vld,
	output cxalu_pkg::item_t      item
);

	localparam int W  = cxalu_pkg::W;
	localparam int F  = cxalu_pkg::F;
	localparam int PW = cxalu_pkg::PW;
	localparam int XW = cxalu_pkg::XW;
	localparam int MW = cxalu_pkg::MW;
	localparam int DW = cxalu_pkg::DW;
	localparam int RW = cxalu_pkg::RW;
	localparam int NW = cxalu_pkg::NW;
	localparam logic [MW:0] RND_HALF = (MW+1)'(1) << (F - 1);

	// s1: operands and the six products
	logic                       vld_s1;
	cxalu_pkg::operands_t       opd_s1;
	logic signed [PW-1:0]       prr_s1, pii_s1, pri_s1, pir_s1;
	logic [DW-1:0]              sqr_s1, sqi_s1;

	// s2: signed pre-results and |b|^2
	logic                       vld_s2, dz_s2;
	cxalu_pkg::op_t             op_s2;
	logic signed [XW-1:0]       xre_s2, xim_s2;
	logic [DW-1:0]              den_s2;

	// s3: sign and magnitude
	logic                       vld_s3, dz_s3;
	cxalu_pkg::op_t             op_s3;
	logic                       nre_s3, nim_s3;
	logic [MW-1:0]              mre_s3, mim_s3;
	logic [DW-1:0]              den_s3;

	// s4: rounded magnitudes or divider dividends
	logic                       vld_s4, dz_s4, div_s4;
	logic                       nre_s4, nim_s4, bre_s4, bim_s4;
	logic [W-1:0]               qre_s4, qim_s4;
	logic [NW-1:0]              nre4_s4, nim4_s4;
	logic [DW-1:0]              den_s4;

	logic signed [PW-1:0]       prr_c, pii_c, pri_c, pir_c, sqr_c, sqi_c;
	logic signed [XW-1:0]       xre_c, xim_c;
	logic [MW:0]                rre_c, rim_c;
	logic [RW-1:0]              d2_c;

	always_comb begin
		prr_c = operands.a_real * operands.b_real;
		pii_c = operands.a_imag * operands.b_imag;
		pri_c = operands.a_real * operands.b_imag;
		pir_c = operands.a_imag * operands.b_real;
		sqr_c = operands.b_real * operands.b_real;
		sqi_c = operands.b_imag * operands.b_imag;
	end

	always_ff @(posedge clk) begin
		opd_s1 <= operands;
		prr_s1 <= prr_c;
		pii_s1 <= pii_c;
		pri_s1 <= pri_c;
		pir_s1 <= pir_c;
		sqr_s1 <= DW'(sqr_c);
		sqi_s1 <= DW'(sqi_c);
	end

	always_comb begin
		case (opd_s1.operation)
			cxalu_pkg::OP_ADD: begin
				xre_c = XW'(opd_s1.a_real) + XW'(opd_s1.b_real);
				xim_c = XW'(opd_s1.a_imag) + XW'(opd_s1.b_imag);
			end
			cxalu_pkg::OP_SUB: begin
				xre_c = XW'(opd_s1.a_real) - XW'(opd_s1.b_real);
				xim_c = XW'(opd_s1.a_imag) - XW'(opd_s1.b_imag);
			end
			cxalu_pkg::OP_MUL: begin
				xre_c = XW'(prr_s1) - XW'(pii_s1);
				xim_c = XW'(pri_s1) + XW'(pir_s1);
			end
			default: begin
				xre_c = XW'(prr_s1) + XW'(pii_s1);
				xim_c = XW'(pir_s1) - XW'(pri_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s2  <= opd_s1.operation;
		dz_s2  <= (opd_s1.operation == cxalu_pkg::OP_DIV) && (opd_s1.b_real == '0)
			&& (opd_s1.b_imag == '0);
		xre_s2 <= xre_c;
		xim_s2 <= xim_c;
		den_s2 <= sqr_s1 + sqi_s1;
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		dz_s3  <= dz_s2;
		nre_s3 <= xre_s2[XW-1];
		nim_s3 <= xim_s2[XW-1];
		mre_s3 <= xre_s2[XW-1] ? MW'(-xre_s2) : MW'(xre_s2);
		mim_s3 <= xim_s2[XW-1] ? MW'(-xim_s2) : MW'(xim_s2);
		den_s3 <= den_s2;
	end

	// round to nearest, ties away from zero, on the magnitude
	always_comb begin
		rre_c = ((MW+1)'(mre_s3) + RND_HALF) >> F;
		rim_c = ((MW+1)'(mim_s3) + RND_HALF) >> F;
	end

	always_ff @(posedge clk) begin
		dz_s4  <= dz_s3;
		div_s4 <= (op_s3 == cxalu_pkg::OP_DIV);
		nre_s4 <= nre_s3;
		nim_s4 <= nim_s3;
		den_s4 <= den_s3;
		if (op_s3 == cxalu_pkg::OP_MUL) begin
			qre_s4 <= rre_c[W-1:0];
			qim_s4 <= rim_c[W-1:0];
			bre_s4 <= |rre_c[MW:W];
			bim_s4 <= |rim_c[MW:W];
		end else begin
			qre_s4 <= mre_s3[W-1:0];
			qim_s4 <= mim_s3[W-1:0];
			bre_s4 <= |mre_s3[MW-1:W];
			bim_s4 <= |mim_s3[MW-1:W];
		end
		// (|num| * 2^(F+1) + den) / (2*den) rounds half away from zero
		nre4_s4 <= (NW'(mre_s3) << (F + 1)) + NW'(den_s3);
		nim4_s4 <= (NW'(mim_s3) << (F + 1)) + NW'(den_s3);
	end

	assign d2_c = {den_s4, 1'b0};

	// s5: quotient overflow check and divider entry
	always_ff @(posedge clk) begin
		item.is_div <= div_s4;
		item.dz     <= dz_s4;
		item.d2     <= d2_c;
		item.re.neg <= nre_s4;
		item.im.neg <= nim_s4;
		if (div_s4) begin
			item.re.big  <= RW'(nre4_s4[NW-1:W]) >= d2_c;
			item.im.big  <= RW'(nim4_s4[NW-1:W]) >= d2_c;
			item.re.q    <= '0;
			item.im.q    <= '0;
			item.re.rem  <= RW'(nre4_s4[NW-1:W]);
			item.im.rem  <= RW'(nim4_s4[NW-1:W]);
			item.re.nlow <= nre4_s4[W-1:0];
			item.im.nlow <= nim4_s4[W-1:0];
		end else begin
			item.re.big  <= bre_s4;
			item.im.big  <= bim_s4;
			item.re.q    <= qre_s4;
			item.im.q    <= qim_s4;
			item.re.rem  <= '0;
			item.im.rem  <= '0;
			item.re.nlow <= '0;
			item.im.nlow <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld    <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld    <= vld_s4;
		end
	end

endmodule

// ----- sv/cxalu_cell.sv -----
module cxalu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_vld,
	input  cxalu_pkg::item_t  feed,
	output logic              vld,
	output cxalu_pkg::item_t  item
);

	localparam int W  = cxalu_pkg::W;
	localparam int RW = cxalu_pkg::RW;

	cxalu_pkg::item_t  nxt_c;

	// one restoring division step: one quotient bit per part
	function automatic cxalu_pkg::part_t step(input cxalu_pkg::part_t p,
		input logic [RW-1:0] d2);
		logic [RW:0]       t;
		logic [RW:0]       diff;
		logic              ge;
		cxalu_pkg::part_t  r;
		t    = {p.rem, p.nlow[W-1]};
		diff = t - {1'b0, d2};
		ge   = t >= {1'b0, d2};
		r    = p;
		r.rem  = ge ? diff[RW-1:0] : t[RW-1:0];
		r.q    = {p.q[W-2:0], ge};
		r.nlow = {p.nlow[W-2:0], 1'b0};
		return r;
	endfunction

	always_comb begin
		nxt_c = feed;
		if (feed.is_div) begin
			nxt_c.re = step(feed.re, feed.d2);
			nxt_c.im = step(feed.im, feed.d2);
		end
	end

	always_ff @(posedge clk) begin
		item <= nxt_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			vld <= feed_vld;
		end
	end

endmodule

// ----- sv/complex_number_alu_top.sv -----
// Complex ALU on signed Q16.16 operands: add, subtract, multiply or divide of
// a and b, one result per accepted command. A command transfers on any edge
// with start high; busy is always low, so a new command may follow every
// cycle. Each result is driven onto the result ports on a single-cycle done
// strobe and transfers in command order; the receiver cannot stall, so it
// must take the result in that cycle. A command passes through the
// multiplier front end (five stages: products, sums, sign/magnitude,
// rounding or dividend build, overflow check), a row of 32 division cells
// producing one quotient bit each, and the output register. Parts that do
// not fit in 32 bits are clamped and flag saturated; divide by 0 + 0i gives
// zero parts with divide_by_zero set and saturated clear.
module complex_number_alu_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cxalu_pkg::operands_t  operands,
	output logic                  done,
	output cxalu_pkg::result_t    result
);

	localparam int W = cxalu_pkg::W;
	localparam logic [W-1:0] HALF = W'(1) << (W - 1);

	logic              chain_vld  [0:W];
	cxalu_pkg::item_t  chain_item [0:W];

	logic [W-1:0]      re_c, im_c;
	logic              re_sat_c, im_sat_c;

	// fully pipelined: never holds a command off
	assign busy = 1'b0;

	cxalu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operands (operands),
		.vld      (chain_vld[0]),
		.item     (chain_item[0])
	);

	// one cell per quotient bit, MSB first
	for (genvar g = 0; g < W; g++) begin : g_cell
		cxalu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.feed_vld (chain_vld[g]),
			.feed     (chain_item[g]),
			.vld      (chain_vld[g+1]),
			.item     (chain_item[g+1])
		);
	end

	// clamp a sign/magnitude part to the word range
	function automatic logic [W:0] clamp(input cxalu_pkg::part_t p);
		logic [W:0] r;
		if (p.neg) begin
			if (p.big || (p.q > HALF)) r = {1'b1, HALF};
			else                        r = {1'b0, W'(-p.q)};
		end else begin
			if (p.big || p.q[W-1])      r = {1'b1, ~HALF};
			else                        r = {1'b0, p.q};
		end
		return r;
	endfunction

	always_comb begin
		{re_sat_c, re_c} = clamp(chain_item[W].re);
		{im_sat_c, im_c} = clamp(chain_item[W].im);
	end

	always_ff @(posedge clk) begin
		if (chain_item[W].dz) begin
			result.result_real <= '0;
			result.result_imag <= '0;
			result.saturated   <= 1'b0;
		end else begin
			result.result_real <= re_c;
			result.result_imag <= im_c;
			result.saturated   <= re_sat_c | im_sat_c;
		end
		result.divide_by_zero <= chain_item[W].dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain_vld[W];
		end
	end

endmodule

// ----- bench/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cxalu_pkg::*;

	// Expected-result store with running mismatch count
	class cx_scoreboard;
		result_t pending[$];
		int      errors;
		int      checked;

		function void note_command(result_t r);
			pending.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				report("result with no command outstanding");
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.result_real !== exp.result_real)
				report($sformatf("real got %h want %h", got.result_real, exp.result_real));
			if (got.result_imag !== exp.result_imag)
				report($sformatf("imag got %h want %h", got.result_imag, exp.result_imag));
			if (got.divide_by_zero !== exp.divide_by_zero)
				report($sformatf("divide_by_zero got %b want %b",
					got.divide_by_zero, exp.divide_by_zero));
			if (got.saturated !== exp.saturated)
				report($sformatf("saturated got %b want %b", got.saturated, exp.saturated));
		endtask
	endclass

	localparam int LATENCY = 38;
	localparam int LIMIT   = 200000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	operands_t operands;
	logic      done;
	result_t   result;

	cx_scoreboard sb;
	int cycles;
	int idle_pct;
	int sent;
	int n_op[4];

	complex_number_alu_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Clamp an exact part to the word; flags sat when clamped
	function automatic logic signed [W-1:0] clamp(logic signed [127:0] v, inout logic sat);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (W - 1)) - 1;
		lo = -(128'sd1 <<< (W - 1));
		if (v > hi) begin
			sat = 1'b1;
			return hi[W-1:0];
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// Signed division rounded to nearest, ties away from zero
	function automatic logic signed [127:0] div_round(logic signed [127:0] n,
			logic signed [127:0] d);
		logic signed [127:0] m, q;
		m = (n < 0) ? -n : n;
		q = (2 * m + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic result_t complex_result(operands_t c);
		result_t r;
		logic signed [127:0] ar, ai, br, bi, re, im, den, half;
		logic sat;
		ar = c.a_real; ai = c.a_imag; br = c.b_real; bi = c.b_imag;
		sat = 1'b0;
		r.divide_by_zero = 1'b0;
		half = 128'sd1 <<< (F - 1);
		case (c.operation)
			OP_ADD: begin re = ar + br; im = ai + bi; end
			OP_SUB: begin re = ar - br; im = ai - bi; end
			OP_MUL: begin
				re = ar * br - ai * bi;
				im = ar * bi + ai * br;
				// round magnitude, ties away from zero
				re = (re < 0) ? -((-re + half) >>> F) : ((re + half) >>> F);
				im = (im < 0) ? -((-im + half) >>> F) : ((im + half) >>> F);
			end
			default: begin
				if (br == 0 && bi == 0) begin
					r.divide_by_zero = 1'b1;
					re = 0; im = 0;
				end else begin
					den = br * br + bi * bi;
					re = div_round((ar * br + ai * bi) <<< F, den);
					im = div_round((ai * br - ar * bi) <<< F, den);
				end
			end
		endcase
		r.result_real = clamp(re, sat);
		r.result_imag = clamp(im, sat);
		r.saturated = sat;
		return r;
	endfunction

	// Results are taken on every edge with done high
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[complex_number_alu_top] ERROR");
			$finish;
		end
	end

	function automatic logic [W-1:0] rand_part();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(W-1){1'b1}}};
			1: return {1'b1, {(W-1){1'b0}}};
			2: return '0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
			5: return $signed($urandom) >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// One command transfer; a random idle gap first when idling is on
	task send(operands_t c);
		while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		operands <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(complex_result(c));
		n_op[c.operation]++;
		sent++;
	endtask

	task send_fields(op_t op, logic [W-1:0] a_r, logic [W-1:0] a_i,
			logic [W-1:0] b_r, logic [W-1:0] b_i);
		operands_t c;
		c.operation = op;
		c.a_real = a_r; c.a_imag = a_i; c.b_real = b_r; c.b_imag = b_i;
		send(c);
	endtask

	task send_random();
		operands_t c;
		c.operation = op_t'($urandom_range(0, 3));
		c.a_real = rand_part(); c.a_imag = rand_part();
		c.b_real = rand_part(); c.b_imag = rand_part();
		// occasional zero divisor
		if (c.operation == OP_DIV && $urandom_range(0, 15) == 0) begin
			c.b_real = '0; c.b_imag = '0;
		end
		send(c);
	endtask

	localparam logic [W-1:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [W-1:0] MINV = 32'h8000_0000;
	localparam logic [W-1:0] ONE  = 32'h0001_0000;

	initial begin
		sb = new();
		cycles = 0;
		sent = 0;
		idle_pct = 0;
		start = 1'b0;
		operands = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each operation, overflow, zero divisor, ties
		send_fields(OP_ADD, MAXV, MINV, MAXV, MINV);
		send_fields(OP_ADD, ONE, -ONE, -ONE, ONE);
		send_fields(OP_SUB, MAXV, MINV, MINV, MAXV);
		send_fields(OP_SUB, 0, 0, 0, 0);
		send_fields(OP_MUL, MAXV, MAXV, MAXV, MAXV);
		send_fields(OP_MUL, MINV, MINV, MINV, MINV);
		send_fields(OP_MUL, MINV, 0, MINV, 0);
		send_fields(OP_MUL, 32'h0000_8000, 0, 1, 0);   // tie rounds away
		send_fields(OP_MUL, -32'sh0000_8000, 0, 1, 0);
		send_fields(OP_MUL, ONE, ONE, ONE, -ONE);
		send_fields(OP_DIV, ONE, ONE, 0, 0);
		send_fields(OP_DIV, MAXV, MINV, 0, 0);
		send_fields(OP_DIV, MAXV, MAXV, 1, 0);
		send_fields(OP_DIV, MINV, MINV, 1, 1);
		send_fields(OP_DIV, ONE, 0, 32'h0002_0000, 0);
		send_fields(OP_DIV, 1, 0, 32'h0002_0000, 0);
		send_fields(OP_DIV, -1, 0, 32'h0002_0000, 0);
		send_fields(OP_DIV, ONE, ONE, ONE, ONE);
		send_fields(OP_DIV, MINV, MAXV, MINV, MAXV);
		send_fields(OP_DIV, 0, 0, MINV, MINV);

		// random phases: no idling, sender idle 45%, then 6%, then none again
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 45;
				2: idle_pct = 6;
				default: idle_pct = 0;
			endcase
			for (int i = 0; i < 400; i++) send_random();
		end
		start <= 1'b0;

		// drain then the pipeline's own depth
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		$display("%0d commands (add %0d sub %0d mul %0d div %0d), %0d results checked",
			sent, n_op[0], n_op[1], n_op[2], n_op[3], sb.checked);
		$display("idle phases: none, 45%%, 6%%; %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("[complex_number_alu_top] OK");
		else
			$display("[complex_number_alu_top] ERROR");
		$finish;
	end
endmodule
